>>> sv/cdq_pkg.sv
// Shared constants, types and index helpers for the circular deque.
`default_nettype none
package cdq_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int CAP_W     = 7;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 2;
    localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_SLOTS);

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_REAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic cap_we;
    } dp_cmd_t;

    // A zero capacity acts as one, and anything above the slot count as the slot count.
    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] c);
        logic [CMP_W-1:0] cw;
        cw = CMP_W'(c);
        if (cw == '0)
            return CNT_W'(1);
        else if (cw > CMP_W'(MAX_SLOTS))
            return CNT_W'(MAX_SLOTS);
        else
            return CNT_W'(cw);
    endfunction

    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
        if (CNT_W'(idx) >= CNT_W'(cap - CNT_W'(1)))
            return '0;
        else
            return IDX_W'(idx + IDX_W'(1));
    endfunction

    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cap);
        if (idx == '0)
            return IDX_W'(cap - CNT_W'(1));
        else
            return IDX_W'(idx - IDX_W'(1));
    endfunction

endpackage
`default_nettype wire

>>> sv/cdq_if.sv
// Handshake channel interfaces for operations, results and the capacity write.
`default_nettype none
interface cdq_op_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::CMD_W-1:0]           cmd;
    logic signed [cdq_pkg::WORD_W-1:0]   data_value;

    modport source (output valid, output cmd, output data_value, input ready);
    modport sink   (input valid, input cmd, input data_value, output ready);
endinterface

interface cdq_res_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic signed [cdq_pkg::WORD_W-1:0]   front_value;
    logic signed [cdq_pkg::WORD_W-1:0]   rear_value;
    logic                                is_empty;
    logic                                is_full;

    modport source (output valid, output accepted, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input accepted, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cdq_pkg::CAP_W-1:0]   capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface
`default_nettype wire

>>> sv/circular_deque_ring_buffer_unit.sv
// Top level of the circular deque: controller, datapath and channel wiring.
`default_nettype none
// Double-ended ring buffer of signed 32-bit words held in a 64-entry RAM. Each item on the op
// channel inserts or deletes at the front or rear and produces one item on the res channel.
// One item is in flight at a time: it is accepted in the idle state, the two end slots are read in
// the read state through the RAM's registered read ports, and the result is shown in the show
// state until taken, so an item also waits on res.ready. The capacity
// register is always ready and is to be written only while no item is in flight.
module circular_deque_ring_buffer_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    cdq_op_if.sink    op,
    cdq_res_if.source res,
    cdq_cfg_if.sink   cfg
);

    cdq_pkg::dp_cmd_t dp_cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op.valid),
        .op_ready  (op.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .dp_cmd    (dp_cmd)
    );

    cdq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .op_cmd       (op.cmd),
        .op_data      (op.data_value),
        .cfg_capacity (cfg.capacity),
        .accepted     (res.accepted),
        .front_value  (res.front_value),
        .rear_value   (res.rear_value),
        .is_empty     (res.is_empty),
        .is_full      (res.is_full)
    );

endmodule
`default_nettype wire

>>> sv/cdq_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

>>> sv/cdq_ctrl.sv
// Controller state machine: sequences accept, slot read and result hand-off.
`default_nettype none
module cdq_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       op_valid,
    output logic            op_ready,
    output logic            res_valid,
    input  wire logic       res_ready,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    output cdq_pkg::dp_cmd_t dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SHOW = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign op_ready      = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_SHOW);
    assign cfg_ready     = 1'b1;
    assign dp_cmd.load   = op_valid && (state_reg == S_IDLE);
    assign dp_cmd.rd_en  = (state_reg == S_READ);
    assign dp_cmd.cap_we = cfg_valid;

endmodule
`default_nettype wire

>>> sv/cdq_dp.sv
// Datapath: end indices, fill count, capacity register and the slot RAM.
`default_nettype none
module cdq_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cdq_pkg::dp_cmd_t                     dp_cmd,
    input  wire logic [cdq_pkg::CMD_W-1:0]            op_cmd,
    input  wire logic signed [cdq_pkg::WORD_W-1:0]    op_data,
    input  wire logic [cdq_pkg::CAP_W-1:0]            cfg_capacity,
    output logic                                      accepted,
    output logic signed [cdq_pkg::WORD_W-1:0]         front_value,
    output logic signed [cdq_pkg::WORD_W-1:0]         rear_value,
    output logic                                      is_empty,
    output logic                                      is_full
);

    logic [cdq_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [cdq_pkg::IDX_W-1:0]  tail_reg, tail_next;
    logic [cdq_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [cdq_pkg::CAP_W-1:0]  capacity_reg;
    logic                       accepted_reg, accepted_next;

    logic [cdq_pkg::CNT_W-1:0]  cap;
    logic                       full;
    logic                       empty;
    logic                       wr_en;
    logic [cdq_pkg::IDX_W-1:0]  wr_addr;
    logic [cdq_pkg::WORD_W-1:0] rd_front;
    logic [cdq_pkg::WORD_W-1:0] rd_rear;

    assign cap   = cdq_pkg::eff_capacity(capacity_reg);
    assign full  = (fill_reg >= cap);
    assign empty = (fill_reg == '0);

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        accepted_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        unique case (op_cmd)
            cdq_pkg::CMD_INS_FRONT, cdq_pkg::CMD_INS_REAR:
            begin
                if (!full)
                begin
                    accepted_next = 1'b1;
                    wr_en         = 1'b1;
                    fill_next     = cdq_pkg::CNT_W'(fill_reg + cdq_pkg::CNT_W'(1));
                    // An insert into an empty deque restarts both ends at slot zero.
                    if (empty)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end
                    else if (op_cmd == cdq_pkg::CMD_INS_FRONT)
                    begin
                        head_next = cdq_pkg::step_back(head_reg, cap);
                        wr_addr   = head_next;
                    end
                    else
                    begin
                        tail_next = cdq_pkg::step_fwd(tail_reg, cap);
                        wr_addr   = tail_next;
                    end
                end
            end
            cdq_pkg::CMD_DEL_FRONT, cdq_pkg::CMD_DEL_REAR:
            begin
                if (!empty)
                begin
                    accepted_next = 1'b1;
                    fill_next     = cdq_pkg::CNT_W'(fill_reg - cdq_pkg::CNT_W'(1));
                    if (op_cmd == cdq_pkg::CMD_DEL_FRONT)
                        head_next = cdq_pkg::step_fwd(head_reg, cap);
                    else
                        tail_next = cdq_pkg::step_back(tail_reg, cap);
                end
            end
            default:
            begin
                accepted_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            capacity_reg <= cdq_pkg::CAP_RESET;
            accepted_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.load)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                fill_reg     <= fill_next;
                accepted_reg <= accepted_next;
            end
            if (dp_cmd.cap_we)
                capacity_reg <= cfg_capacity;
        end
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (cdq_pkg::MAX_SLOTS)
    ) u_slots (
        .clk     (clk),
        .we      (wr_en && dp_cmd.load),
        .waddr   (wr_addr),
        .wdata   (op_data),
        .re      (dp_cmd.rd_en),
        .raddr_a (head_reg),
        .raddr_b (tail_reg),
        .rdata_a (rd_front),
        .rdata_b (rd_rear)
    );

    assign accepted    = accepted_reg;
    assign is_empty    = empty;
    assign is_full     = full;
    assign front_value = empty ? '1 : rd_front;
    assign rear_value  = empty ? '1 : rd_rear;

endmodule
`default_nettype wire

>>> sv/cdq_checker.sv
// Port-level checker for the circular deque and its bind to the top level.
`default_nettype none
module cdq_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                op_valid,
    input wire logic                                op_ready,
    input wire logic                                res_valid,
    input wire logic                                res_ready,
    input wire logic                                res_accepted,
    input wire logic signed [cdq_pkg::WORD_W-1:0]   res_front,
    input wire logic signed [cdq_pkg::WORD_W-1:0]   res_rear,
    input wire logic                                res_is_empty,
    input wire logic                                res_is_full
);

    // Only one item is in flight, so no item is taken while a result is shown.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !op_ready)
        else $error("item accepted while a result is pending");

    // A result never appears in the cycle right after its item is accepted.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && op_ready) |=> !res_valid)
        else $error("result shown before the slot read");

    // Once a result is taken, the block is ready for the next item.
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> op_ready)
        else $error("block not ready after result hand-off");

    // An empty deque shows all-ones end words and is never full.
    a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_is_empty) |->
            (res_front == -32'sd1) && (res_rear == -32'sd1) && !res_is_full)
        else $error("empty result with bad end words or full flag");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            res_valid && $stable(res_front) && $stable(res_rear) && $stable(res_accepted))
        else $error("stalled result changed");

endmodule

bind circular_deque_ring_buffer_unit cdq_checker u_cdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_valid     (op.valid),
    .op_ready     (op.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_accepted (res.accepted),
    .res_front    (res.front_value),
    .res_rear     (res.rear_value),
    .res_is_empty (res.is_empty),
    .res_is_full  (res.is_full)
);
`default_nettype wire

>>> test/circular_deque_ring_buffer_unit_test.sv
// Testbench for the circular deque: random and directed items checked against a predictor.
module circular_deque_ring_buffer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [cdq_pkg::CMD_W-1:0]         cmd;
        logic signed [cdq_pkg::WORD_W-1:0] data_value;
    } deque_op_t;

    typedef struct {
        logic                              accepted;
        logic signed [cdq_pkg::WORD_W-1:0] front_value;
        logic signed [cdq_pkg::WORD_W-1:0] rear_value;
        logic                              is_empty;
        logic                              is_full;
    } deque_view_t;

    logic clk;
    logic rst_n;

    cdq_op_if  op_ch ();
    cdq_res_if res_ch ();
    cdq_cfg_if cfg_ch ();

    circular_deque_ring_buffer_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    deque_op_t   pending_ops[$];
    deque_view_t expected_views[$];
    int          errors = 0;
    int          results_seen = 0;
    logic        no_idle = 1'b0;

    // Shadow copy of the deque.
    logic signed [cdq_pkg::WORD_W-1:0] shadow_slots [cdq_pkg::MAX_SLOTS];
    logic [cdq_pkg::IDX_W-1:0]         shadow_head = '0;
    logic [cdq_pkg::IDX_W-1:0]         shadow_tail = '0;
    logic [cdq_pkg::CAP_W-1:0]         shadow_fill = '0;
    logic [cdq_pkg::CAP_W-1:0]         capacity_setting = cdq_pkg::CAP_RESET;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [cdq_pkg::CAP_W-1:0] usable_slots(
        input logic [cdq_pkg::CAP_W-1:0] c);
        if (c == '0)
            return cdq_pkg::CAP_W'(1);
        else if (c > cdq_pkg::CAP_W'(cdq_pkg::MAX_SLOTS))
            return cdq_pkg::CAP_W'(cdq_pkg::MAX_SLOTS);
        else
            return c;
    endfunction

    function automatic logic [cdq_pkg::IDX_W-1:0] wrap_next(
        input logic [cdq_pkg::IDX_W-1:0] idx, input logic [cdq_pkg::CAP_W-1:0] cap);
        if (cdq_pkg::CAP_W'(idx) >= cap - cdq_pkg::CAP_W'(1))
            return '0;
        else
            return idx + cdq_pkg::IDX_W'(1);
    endfunction

    function automatic logic [cdq_pkg::IDX_W-1:0] wrap_prev(
        input logic [cdq_pkg::IDX_W-1:0] idx, input logic [cdq_pkg::CAP_W-1:0] cap);
        if (idx == '0)
            return cdq_pkg::IDX_W'(cap - cdq_pkg::CAP_W'(1));
        else
            return idx - cdq_pkg::IDX_W'(1);
    endfunction

    // Applies one item to the shadow deque and returns the view the block should report.
    function automatic deque_view_t apply_deque_op(input logic [cdq_pkg::CMD_W-1:0] cmd,
                                                   input logic signed [cdq_pkg::WORD_W-1:0] word);
        deque_view_t               view;
        logic [cdq_pkg::CAP_W-1:0] cap;
        logic                      done;
        cap  = usable_slots(capacity_setting);
        done = 1'b0;
        if (cmd == cdq_pkg::CMD_INS_FRONT || cmd == cdq_pkg::CMD_INS_REAR)
        begin
            if (shadow_fill < cap)
            begin
                if (shadow_fill == '0)
                begin
                    shadow_head     = '0;
                    shadow_tail     = '0;
                    shadow_slots[0] = word;
                end
                else if (cmd == cdq_pkg::CMD_INS_FRONT)
                begin
                    shadow_head               = wrap_prev(shadow_head, cap);
                    shadow_slots[shadow_head] = word;
                end
                else
                begin
                    shadow_tail               = wrap_next(shadow_tail, cap);
                    shadow_slots[shadow_tail] = word;
                end
                shadow_fill = shadow_fill + cdq_pkg::CAP_W'(1);
                done        = 1'b1;
            end
        end
        else if (shadow_fill != '0)
        begin
            if (cmd == cdq_pkg::CMD_DEL_FRONT)
                shadow_head = wrap_next(shadow_head, cap);
            else
                shadow_tail = wrap_prev(shadow_tail, cap);
            shadow_fill = shadow_fill - cdq_pkg::CAP_W'(1);
            done        = 1'b1;
        end
        view.accepted    = done;
        view.is_empty    = (shadow_fill == '0);
        view.is_full     = (shadow_fill >= cap);
        view.front_value = view.is_empty ? -32'sd1 : shadow_slots[shadow_head];
        view.rear_value  = view.is_empty ? -32'sd1 : shadow_slots[shadow_tail];
        return view;
    endfunction

    function automatic logic signed [cdq_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return -32'sd1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [cdq_pkg::WORD_W-1:0] got,
                               input logic [cdq_pkg::WORD_W-1:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got %h, expected %h",
                             results_seen, name, got, want));
    endtask

    task automatic push_op(input logic [cdq_pkg::CMD_W-1:0] cmd,
                           input logic signed [cdq_pkg::WORD_W-1:0] word);
        deque_op_t item;
        item.cmd        = cmd;
        item.data_value = word;
        pending_ops     = {pending_ops, item};
    endtask

    task automatic wait_idle();
        do @(posedge clk); while (pending_ops.size() != 0);
        do @(posedge clk); while (op_ch.valid || expected_views.size() != 0);
    endtask

    task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid     <= 1'b0;
        capacity_setting = value;
    endtask

    // Holds each item until it is taken and predicts its result at that edge.
    always @(posedge clk)
    begin : op_driver
        deque_op_t item;
        if (!rst_n)
            op_ch.valid <= 1'b0;
        else
        begin
            if (op_ch.valid && op_ch.ready)
                expected_views = {expected_views,
                                  apply_deque_op(op_ch.cmd, op_ch.data_value)};
            if (!op_ch.valid || op_ch.ready)
            begin
                if (pending_ops.size() != 0 && (no_idle || $urandom_range(0, 99) >= 25))
                begin
                    item = pending_ops[0];
                    pending_ops.delete(0);
                    op_ch.valid      <= 1'b1;
                    op_ch.cmd        <= item.cmd;
                    op_ch.data_value <= item.data_value;
                end
                else
                    op_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : res_monitor
        deque_view_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_views.size() == 0)
                    report($sformatf("result %0d arrived with nothing expected", results_seen));
                else
                begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    check_field("accepted", cdq_pkg::WORD_W'(res_ch.accepted),
                                cdq_pkg::WORD_W'(want.accepted));
                    check_field("front_value", res_ch.front_value, want.front_value);
                    check_field("rear_value", res_ch.rear_value, want.rear_value);
                    check_field("is_empty", cdq_pkg::WORD_W'(res_ch.is_empty),
                                cdq_pkg::WORD_W'(want.is_empty));
                    check_field("is_full", cdq_pkg::WORD_W'(res_ch.is_full),
                                cdq_pkg::WORD_W'(want.is_full));
                end
            end
            res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin : stimulus
        int                        phase_no;
        int                        phase_items;
        int                        random_done;
        int                        insert_pct;
        logic [cdq_pkg::CAP_W-1:0] cap_value;
        rst_n              = 1'b0;
        op_ch.valid        = 1'b0;
        op_ch.cmd          = cdq_pkg::CMD_INS_FRONT;
        op_ch.data_value   = '0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.capacity    = cdq_pkg::CAP_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole store at full capacity first, so that no slot is ever read unwritten
        // once the capacity starts to move.
        push_op(cdq_pkg::CMD_INS_REAR, 32'h8000_0000);
        push_op(cdq_pkg::CMD_INS_REAR, 32'h7FFF_FFFF);
        push_op(cdq_pkg::CMD_INS_REAR, '0);
        push_op(cdq_pkg::CMD_INS_REAR, -32'sd1);
        for (int i = 0; i < cdq_pkg::MAX_SLOTS - 4; i++)
            push_op(cdq_pkg::CMD_INS_REAR, random_word());
        push_op(cdq_pkg::CMD_INS_FRONT, random_word());
        push_op(cdq_pkg::CMD_INS_REAR, random_word());
        push_op(cdq_pkg::CMD_DEL_REAR, random_word());
        push_op(cdq_pkg::CMD_INS_FRONT, random_word());
        push_op(cdq_pkg::CMD_DEL_FRONT, random_word());
        push_op(cdq_pkg::CMD_INS_REAR, random_word());
        for (int i = 0; i < cdq_pkg::MAX_SLOTS / 2; i++)
        begin
            push_op(cdq_pkg::CMD_DEL_FRONT, random_word());
            push_op(cdq_pkg::CMD_DEL_REAR, random_word());
        end
        push_op(cdq_pkg::CMD_DEL_FRONT, random_word());
        push_op(cdq_pkg::CMD_DEL_REAR, random_word());
        push_op(cdq_pkg::CMD_INS_FRONT, random_word());
        push_op(cdq_pkg::CMD_INS_REAR, random_word());
        push_op(cdq_pkg::CMD_INS_FRONT, random_word());
        wait_idle();

        // A zero capacity acts as one and lands below the current fill.
        write_capacity('0);
        push_op(cdq_pkg::CMD_INS_REAR, random_word());
        push_op(cdq_pkg::CMD_DEL_FRONT, random_word());
        push_op(cdq_pkg::CMD_DEL_REAR, random_word());
        push_op(cdq_pkg::CMD_DEL_FRONT, random_word());
        push_op(cdq_pkg::CMD_INS_FRONT, random_word());
        push_op(cdq_pkg::CMD_INS_REAR, random_word());
        push_op(cdq_pkg::CMD_DEL_REAR, random_word());
        wait_idle();

        phase_no    = 0;
        random_done = 0;
        insert_pct  = 50;
        while (random_done < 360)
        begin
            case (phase_no)
                0: cap_value = 7'd127;
                1: cap_value = 7'd1;
                2: cap_value = cdq_pkg::CAP_W'(cdq_pkg::MAX_SLOTS);
                default:
                    case ($urandom_range(0, 9))
                        0:       cap_value = '0;
                        1:       cap_value = cdq_pkg::CAP_W'(
                                     $urandom_range(cdq_pkg::MAX_SLOTS + 1, 127));
                        2:       cap_value = cdq_pkg::CAP_W'(cdq_pkg::MAX_SLOTS);
                        3, 4:    cap_value = cdq_pkg::CAP_W'(
                                     $urandom_range(17, cdq_pkg::MAX_SLOTS - 1));
                        default: cap_value = cdq_pkg::CAP_W'($urandom_range(1, 16));
                    endcase
            endcase
            write_capacity(cap_value);
            no_idle     = (phase_no == 3);
            phase_items = no_idle ? 90 : $urandom_range(20, 60);
            for (int i = 0; i < phase_items; i++)
            begin
                // Short bursts that lean toward filling or draining reach both ends often.
                if (i % 12 == 0)
                    case ($urandom_range(0, 2))
                        0:       insert_pct = 15;
                        1:       insert_pct = 50;
                        default: insert_pct = 85;
                    endcase
                if ($urandom_range(0, 99) < insert_pct)
                    push_op($urandom_range(0, 1) ? cdq_pkg::CMD_INS_REAR : cdq_pkg::CMD_INS_FRONT,
                            random_word());
                else
                    push_op($urandom_range(0, 1) ? cdq_pkg::CMD_DEL_REAR : cdq_pkg::CMD_DEL_FRONT,
                            random_word());
            end
            random_done += phase_items;
            wait_idle();
            no_idle = 1'b0;
            phase_no++;
        end

        // The wait after the last item catches any stray result.
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("circular_deque_ring_buffer_unit_test OK");
        else
            $display("circular_deque_ring_buffer_unit_test NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("ERROR: timeout");
        $display("circular_deque_ring_buffer_unit_test NOT OK");
        $finish;
    end

endmodule
